/* rtl/sacsd_pkg.sv */
package sacsd_pkg;

    localparam int unsigned RX_W      = 8;
    localparam int unsigned LIMIT_W   = 7;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned ANGLE_W   = 8;
    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 3;

    localparam logic [RX_W-1:0]    CR_CHAR    = 8'd13;
    localparam logic [RX_W-1:0]    SIGN_PLUS  = 8'h2b;
    localparam logic [RX_W-1:0]    SIGN_MINUS = 8'h2d;
    localparam logic [RX_W-1:0]    DIGIT_LO   = 8'h30;
    localparam logic [RX_W-1:0]    DIGIT_HI   = 8'h39;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 3'd7;
    localparam logic [COUNT_W-1:0] KEEP_CHARS = 3'd3;
    localparam logic [COUNT_W-1:0] SHORT_LINE = 3'd2;

    localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST = 7'd90;

    // duty = (270 + angle) * 25 / 72, done as one multiply by ceil(25 * 2^19 / 72)
    localparam int unsigned CENTER_DEG = 270;
    localparam int unsigned DUTY_SHIFT = 19;
    localparam int unsigned DUTY_RECIP = (25 * (1 << DUTY_SHIFT) + 71) / 72;
    localparam int unsigned SUM_W      = 9;
    localparam int unsigned PROD_W     = 29;

    typedef enum logic [1:0] {
        LS_OPEN   = 2'd0,
        LS_ACCEPT = 2'd1,
        LS_REJECT = 2'd2
    } line_status_t;

endpackage

/* rtl/serial_angle_command_to_servo_duty.sv */
// channel   dir  tdata (low bit up)                             tuser (low bit up)
// s_        in   rx_byte[7:0]                                   -
// m_        out  echo_byte[7:0] angle_deg[15:8] duty[25:16]     line_status[1:0] channel[2]
// cfg_wr_*  in   angle_limit[6:0], taken whenever cfg_wr_en is high
//
// one byte per cycle sustained while m_ is not stalled; a beat goes input register ->
// line parse and duty multiply -> result register, and its result is on m_ from there
// line state (count, first three characters, channel) updates as a beat leaves
// the input register; a stalled result holds both registers and drops s_tready
// once the input register is full
// aresetn is synchronous, active low; clears count, channel and valids, limit back to 90
module serial_angle_command_to_servo_duty (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sacsd_pkg::RX_W-1:0]       s_tdata,   // rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // echo_byte, angle_deg, duty_value, zero pad
    output logic [sacsd_pkg::M_TDATA_W-1:0]  m_tdata,
    // line_status, servo_channel
    output logic [sacsd_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [sacsd_pkg::LIMIT_W-1:0]    cfg_wr_data
);
    import sacsd_pkg::*;

    logic               in_valid_reg;
    logic [RX_W-1:0]    in_byte_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [RX_W-1:0]    chars_reg [KEEP_CHARS];
    logic               chan_reg;

    logic                 out_valid_reg;
    logic [RX_W-1:0]      echo_reg;
    line_status_t         status_reg, status_next;
    logic                 ochan_reg;
    logic [ANGLE_W-1:0]   angle_reg, angle_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;

    logic advance, proc_fire, is_cr;
    logic sign_ok, dig1_ok, dig2_ok, len_ok, accept;
    logic [LIMIT_W-1:0] mag;
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  prod;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign proc_fire = in_valid_reg && advance;
    assign is_cr     = (in_byte_reg == CR_CHAR);

    always_comb begin
        len_ok  = (count_reg == SHORT_LINE) || (count_reg == KEEP_CHARS);
        sign_ok = (chars_reg[0] == SIGN_PLUS) || (chars_reg[0] == SIGN_MINUS);
        dig1_ok = chars_reg[1] inside {[DIGIT_LO:DIGIT_HI]};
        dig2_ok = chars_reg[2] inside {[DIGIT_LO:DIGIT_HI]};
        // ascii digits carry their value in the low nibble
        if (count_reg == KEEP_CHARS) begin
            mag = LIMIT_W'(chars_reg[1][3:0]) * LIMIT_W'(10) + LIMIT_W'(chars_reg[2][3:0]);
        end else begin
            mag = LIMIT_W'(chars_reg[1][3:0]);
        end
        accept = len_ok && sign_ok && dig1_ok
                 && (count_reg != KEEP_CHARS || dig2_ok) && (mag <= limit_reg);
    end

    always_comb begin
        status_next = LS_OPEN;
        angle_next  = '0;
        duty_next   = '0;
        sum         = '0;
        prod        = '0;
        if (is_cr && count_reg != '0) begin
            if (accept) begin
                status_next = LS_ACCEPT;
                if (chars_reg[0] == SIGN_MINUS) begin
                    angle_next = ANGLE_W'(-$signed({1'b0, mag}));
                    sum        = SUM_W'(CENTER_DEG) - SUM_W'(mag);
                end else begin
                    angle_next = ANGLE_W'(mag);
                    sum        = SUM_W'(CENTER_DEG) + SUM_W'(mag);
                end
                prod      = PROD_W'(sum) * PROD_W'(DUTY_RECIP);
                duty_next = prod[DUTY_SHIFT +: DUTY_W];
            end else begin
                status_next = LS_REJECT;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (is_cr) begin
            count_next = '0;
        end else if (count_reg < COUNT_MAX) begin
            count_next = count_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            chan_reg      <= 1'b0;
            limit_reg     <= ANGLE_LIMIT_RST;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc_fire) begin
                count_reg <= count_next;
                if (status_next == LS_ACCEPT) begin
                    chan_reg <= !chan_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (proc_fire && !is_cr && count_reg < KEEP_CHARS) begin
            chars_reg[count_reg[1:0]] <= in_byte_reg;
        end
        if (proc_fire) begin
            echo_reg   <= in_byte_reg;
            status_reg <= status_next;
            ochan_reg  <= chan_reg;
            angle_reg  <= angle_next;
            duty_reg   <= duty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, duty_reg, angle_reg, echo_reg};
    assign m_tuser  = {ochan_reg, status_reg};

    // a line only ends on a carriage return
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] != LS_OPEN) |-> (m_tdata[7:0] == CR_CHAR))
        else $error("line ended on a non carriage return beat");

    // angle and duty are zero unless the angle was accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] != LS_ACCEPT) |-> (m_tdata[25:8] == '0))
        else $error("angle or duty set on a beat that was not accepted");

    // the count restarts after every carriage return
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && is_cr) |=> (count_reg == '0))
        else $error("character count not cleared at end of line");

    // the channel advances exactly when an angle is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && status_next == LS_ACCEPT) |=> (chan_reg != $past(chan_reg)))
        else $error("channel did not advance on acceptance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && status_next != LS_ACCEPT) |=> $stable(chan_reg))
        else $error("channel changed without an accepted angle");

    // an accepted beat always lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted input beat lost");

endmodule
